// ===== rtl/trpd_pkg.sv =====
`default_nettype none
package trpd_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SIXTEEN_COLOUR = 1'b0,
        CFG_PACKED_FORMAT  = 1'b1
    } t_cfg_addr;

    typedef struct packed {
        logic sixteen_colour;
        logic packed_fmt;
    } t_cfg;

    typedef struct packed {
        logic [3:0][7:0] plane;
        logic            flip;
        logic [3:0]      palette;
    } t_row;

    typedef struct packed {
        logic [7:0][3:0] pixel;
        logic [7:0]      mask;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/trpd_decode.sv =====
`default_nettype none
module trpd_decode (
    input  trpd_pkg::t_cfg    i_cfg,
    input  trpd_pkg::t_row    i_row,
    output trpd_pkg::t_result o_result
);
    import trpd_pkg::*;

    logic [7:0][3:0] pix;
    logic            transparent_zero;

    always_comb begin
        logic [7:0] byte_sel;
        byte_sel = '0;
        for (int n = 0; n < 8; n++) begin
            if (i_cfg.packed_fmt) begin
                if (i_cfg.sixteen_colour) begin
                    byte_sel = i_row.plane[2'(n >> 1)];
                    pix[n] = (n % 2 == 1) ? byte_sel[3:0] : byte_sel[7:4];
                end else begin
                    byte_sel = i_row.plane[2'(n >> 2)];
                    pix[n] = {2'b00, byte_sel[3'(7 - 2 * (n % 4)) -: 2]};
                end
            end else begin
                pix[n][0] = i_row.plane[0][3'(7 - n)];
                pix[n][1] = i_row.plane[1][3'(7 - n)];
                pix[n][2] = i_cfg.sixteen_colour & i_row.plane[2][3'(7 - n)];
                pix[n][3] = i_cfg.sixteen_colour & i_row.plane[3][3'(7 - n)];
            end
        end
    end

    // index zero is see-through in 4bpp, or in 2bpp when palette bit 2 is set
    assign transparent_zero = i_cfg.sixteen_colour | i_row.palette[2];

    always_comb begin
        for (int n = 0; n < 8; n++) begin
            o_result.pixel[n] = i_row.flip ? pix[3'(7 - n)] : pix[n];
            o_result.mask[n]  = !transparent_zero || (o_result.pixel[n] != 4'd0);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tile_row_pixel_decode_core.sv =====
`default_nettype none
// Tile row decoder: one 8-pixel tile row (four plane bytes, flip bit, palette number) in,
// eight 4-bit colour indices and an opaque mask out. A row is taken every cycle while
// o_in_stall is low; its result is registered into a two-entry output stage (output
// register, or skid register while the output row is not taken), and o_in_stall is
// raised only while both entries hold rows. Format bits are written through the config
// port and should only change while no rows are in flight.
module tile_row_pixel_decode_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [trpd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [trpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [7:0]                      i_plane_byte_0,
    input  wire [7:0]                      i_plane_byte_1,
    input  wire [7:0]                      i_plane_byte_2,
    input  wire [7:0]                      i_plane_byte_3,
    input  wire                            i_flip_horizontal,
    input  wire [3:0]                      i_palette_number,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [3:0]                     o_pixel_0,
    output logic [3:0]                     o_pixel_1,
    output logic [3:0]                     o_pixel_2,
    output logic [3:0]                     o_pixel_3,
    output logic [3:0]                     o_pixel_4,
    output logic [3:0]                     o_pixel_5,
    output logic [3:0]                     o_pixel_6,
    output logic [3:0]                     o_pixel_7,
    output logic [7:0]                     o_opaque_mask
);
    import trpd_pkg::*;

    t_cfg    r_cfg;
    t_row    row;
    t_result dec;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_xfer;
    logic    out_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_SIXTEEN_COLOUR: r_cfg.sixteen_colour <= i_cfg_data[0];
                CFG_PACKED_FORMAT:  r_cfg.packed_fmt     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign row.plane   = {i_plane_byte_3, i_plane_byte_2, i_plane_byte_1, i_plane_byte_0};
    assign row.flip    = i_flip_horizontal;
    assign row.palette = i_palette_number;

    trpd_decode u_decode (
        .i_cfg    (r_cfg),
        .i_row    (row),
        .o_result (dec)
    );

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_xfer) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_xfer) begin
                if (r_out_valid && !out_xfer) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: skid drains into output first; new rows go where there is room
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (in_xfer) begin
            if (r_out_valid && !out_xfer) begin
                r_skid <= dec;
            end else begin
                r_out <= dec;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_0     = r_out.pixel[0];
    assign o_pixel_1     = r_out.pixel[1];
    assign o_pixel_2     = r_out.pixel[2];
    assign o_pixel_3     = r_out.pixel[3];
    assign o_pixel_4     = r_out.pixel[4];
    assign o_pixel_5     = r_out.pixel[5];
    assign o_pixel_6     = r_out.pixel[6];
    assign o_pixel_7     = r_out.pixel[7];
    assign o_opaque_mask = r_out.mask;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a row while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid loaded while the output register was free");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid row not moved to the output after a transfer");

endmodule
`default_nettype wire
